[design/satlb_pkg.sv]
// ---------------------------------------------------------------------------
// satlb_pkg
// Shared item types, field widths, operation codes and controller states for
// the set-associative translation buffer.
// ---------------------------------------------------------------------------
package satlb_pkg;

    // Field widths fixed by the item format
    localparam int OP_W    = 2;
    localparam int SIDX_W  = 4;
    localparam int TAGIN_W = 20;
    localparam int STAMP_W = 32;
    localparam int FRAME_W = 20;
    localparam int PAGE_W  = 24;

    // Operation codes
    localparam logic [OP_W-1:0] OP_LOOKUP = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT = 2'd1;
    localparam logic [OP_W-1:0] OP_INVAL  = 2'd2;

    // Request item
    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [SIDX_W-1:0]  set_index;
        logic [TAGIN_W-1:0] tag_value;
        logic [STAMP_W-1:0] time_stamp;
        logic [FRAME_W-1:0] frame_number;
        logic [PAGE_W-1:0]  page_number;
    } t_in_item;

    // Response item
    typedef struct packed {
        logic               hit;
        logic [FRAME_W-1:0] hit_frame;
    } t_out_item;

    // Controller states
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SPLIT,
        ST_READ,
        ST_EVAL,
        ST_SCAN,
        ST_COMMIT
    } t_state;

endpackage

[design/satlb_mem.sv]
// ---------------------------------------------------------------------------
// satlb_mem
// Single-port-write, single-port-read synchronous RAM holding one set row
// per entry. Read data is registered and holds until the next read.
// ---------------------------------------------------------------------------
module satlb_mem #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8
) (
    input  logic                                      i_clk,
    input  logic                                      i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                          o_rd_data,
    input  logic                                      i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                          i_wr_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[design/satlb_split.sv]
// ---------------------------------------------------------------------------
// satlb_split
// Splits a number into quotient and remainder by the set count, using a
// reciprocal multiply followed by a back-multiply. Two load stages; the
// remainder is valid the cycle after the quotient stage loads.
// ---------------------------------------------------------------------------
module satlb_split #(
    parameter int SETS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_ld_num,
    input  logic                                    i_ld_quot,
    input  logic [satlb_pkg::PAGE_W-1:0]            i_num,
    output logic [satlb_pkg::PAGE_W-1:0]            o_quot,
    output logic [((SETS > 1) ? $clog2(SETS) : 1)-1:0] o_rem
);

    localparam int NUM_W  = satlb_pkg::PAGE_W;
    localparam int SET_W  = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int DIV_L  = $clog2(SETS);
    localparam int DIV_SH = NUM_W + DIV_L;
    localparam int M_W    = NUM_W + 1;
    localparam int PROD_W = NUM_W + M_W;
    localparam int SETS_W = $clog2(SETS + 1);
    localparam int QD_W   = NUM_W + SETS_W;
    // ceil(2^(N+l) / SETS) gives an exact quotient for every N-bit number
    localparam logic [63:0] DIV_M_FULL =
        ((64'd1 << DIV_SH) + 64'(SETS) - 64'd1) / 64'(SETS);
    localparam logic [M_W-1:0]    DIV_M  = DIV_M_FULL[M_W-1:0];
    localparam logic [SETS_W-1:0] SETS_V = SETS_W'(SETS);

    logic [NUM_W-1:0]  r_num;
    logic [PROD_W-1:0] r_prod;
    logic [NUM_W-1:0]  r_quot;
    logic [QD_W-1:0]   r_qd;
    logic [PROD_W-1:0] prod_sh;
    logic [NUM_W-1:0]  quot_w;
    logic [NUM_W-1:0]  rem_full;

    // Stage 1: capture the number and multiply by the reciprocal
    always_ff @(posedge i_clk) begin
        if (i_ld_num) begin
            r_num  <= i_num;
            r_prod <= PROD_W'(i_num) * PROD_W'(DIV_M);
        end
    end

    assign prod_sh = r_prod >> DIV_SH;
    assign quot_w  = prod_sh[NUM_W-1:0];

    // Stage 2: hold the quotient and multiply it back by the set count
    always_ff @(posedge i_clk) begin
        if (i_ld_quot) begin
            r_quot <= quot_w;
            r_qd   <= QD_W'(quot_w) * QD_W'(SETS_V);
        end
    end

    // Remainder stays below the set count
    assign rem_full = r_num - r_qd[NUM_W-1:0];
    assign o_rem    = rem_full[SET_W-1:0];
    assign o_quot   = r_quot;

endmodule

[design/set_assoc_tlb_lru_unit.sv]
// Sequence: an accepted item passes the split, read, evaluate and commit
//   states; an insert into a full set adds the oldest-stamp scan (one way per cycle).
// Flow: one item at a time; a new item is accepted only after the last one
//   commits, and commit waits until the output register is free.
// Reset: synchronous; a clearing pass writes every set row, with input ready
//   held low until it finishes.
// ---------------------------------------------------------------------------
// set_assoc_tlb_lru_unit
// Set-associative translation buffer with time-stamp LRU replacement. Each
// set row (valid, tag, frame, stamp per way) lives in one synchronous RAM, is
// read once per item and written back for inserts, invalidates and lookup hits.
// ---------------------------------------------------------------------------
module set_assoc_tlb_lru_unit #(
    parameter int SETS     = 16,
    parameter int WAYS     = 4,
    parameter int TAG_BITS = 20
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  satlb_pkg::t_in_item   i_in_item,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output satlb_pkg::t_out_item  o_out_item
);

    localparam int SET_W     = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int WAY_W     = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int FRAME_W   = satlb_pkg::FRAME_W;
    localparam int STAMP_W   = satlb_pkg::STAMP_W;
    localparam int PAGE_W    = satlb_pkg::PAGE_W;
    localparam int ROW_W     = WAYS * (1 + TAG_BITS + FRAME_W + STAMP_W);
    localparam int TAG_SRC_W = (TAG_BITS > PAGE_W) ? TAG_BITS : PAGE_W;

    // Control and payload registers
    satlb_pkg::t_state    r_state, n_state;
    satlb_pkg::t_in_item  r_item, n_item;
    satlb_pkg::t_out_item r_out, n_out;
    logic                 r_out_valid, n_out_valid;
    logic [SET_W-1:0]     r_clr_addr, n_clr_addr;
    logic [SET_W-1:0]     r_set, n_set;
    logic                 r_hit, n_hit;
    logic [WAY_W-1:0]     r_way, n_way;
    logic [WAY_W-1:0]     r_best, n_best;
    logic [WAY_W-1:0]     r_scan, n_scan;

    // Memory port signals
    logic                 mem_rd_en;
    logic [SET_W-1:0]     mem_rd_addr;
    logic [ROW_W-1:0]     mem_rd_data;
    logic                 mem_wr_en;
    logic [SET_W-1:0]     mem_wr_addr;
    logic [ROW_W-1:0]     mem_wr_data;

    // Row fields
    logic [WAYS-1:0]                rd_valid, wr_valid;
    logic [WAYS-1:0][TAG_BITS-1:0]  rd_tag, wr_tag;
    logic [WAYS-1:0][FRAME_W-1:0]   rd_frame, wr_frame;
    logic [WAYS-1:0][STAMP_W-1:0]   rd_stamp, wr_stamp;

    // Split unit signals
    logic                 split_ld_num;
    logic                 split_ld_quot;
    logic [PAGE_W-1:0]    split_num;
    logic [PAGE_W-1:0]    split_quot;
    logic [SET_W-1:0]     split_rem;

    // Compare results
    logic [TAG_SRC_W-1:0] item_tag_ext;
    logic [TAG_SRC_W-1:0] page_tag_ext;
    logic [TAG_BITS-1:0]  item_tag;
    logic [TAG_BITS-1:0]  page_tag;
    logic                 match_hit;
    logic [WAY_W-1:0]     match_way;
    logic                 free_hit;
    logic [WAY_W-1:0]     free_way;
    logic [WAYS-1:0]      inv_mask;
    logic [WAY_W-1:0]     best_next;
    logic                 out_free;
    logic                 in_accept;

    // Set row storage
    satlb_mem #(
        .DEPTH (SETS),
        .WIDTH (ROW_W)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (mem_wr_addr),
        .i_wr_data (mem_wr_data)
    );

    // Set and tag split of the incoming number
    satlb_split #(
        .SETS (SETS)
    ) u_split (
        .i_clk     (i_clk),
        .i_ld_num  (split_ld_num),
        .i_ld_quot (split_ld_quot),
        .i_num     (split_num),
        .o_quot    (split_quot),
        .o_rem     (split_rem)
    );

    assign {rd_valid, rd_tag, rd_frame, rd_stamp} = mem_rd_data;
    assign mem_wr_data = {wr_valid, wr_tag, wr_frame, wr_stamp};

    // Invalidate splits the page number; other ops split the set index only
    assign in_accept    = i_in_valid && o_in_ready;
    assign split_ld_num = in_accept;
    assign split_num    = (i_in_item.op == satlb_pkg::OP_INVAL) ?
                          i_in_item.page_number : PAGE_W'(i_in_item.set_index);

    // Tags kept in their low TAG_BITS bits
    assign item_tag_ext = TAG_SRC_W'(r_item.tag_value);
    assign page_tag_ext = TAG_SRC_W'(split_quot);
    assign item_tag     = item_tag_ext[TAG_BITS-1:0];
    assign page_tag     = page_tag_ext[TAG_BITS-1:0];

    // Compare all ways of the row; lowest-numbered way wins
    always_comb begin
        match_hit = 1'b0;
        match_way = '0;
        free_hit  = 1'b0;
        free_way  = '0;
        inv_mask  = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (rd_valid[w] && (rd_tag[w] == item_tag)) begin
                match_hit = 1'b1;
                match_way = WAY_W'(w);
            end
            if (!rd_valid[w]) begin
                free_hit = 1'b1;
                free_way = WAY_W'(w);
            end
            inv_mask[w] = rd_valid[w] && (rd_tag[w] == page_tag);
        end
    end

    // Oldest-stamp scan step; ties keep the lower way
    assign best_next = (rd_stamp[r_scan] < rd_stamp[r_best]) ? r_scan : r_best;
    assign out_free  = !r_out_valid || i_out_ready;

    // Next state, memory access and result
    always_comb begin
        n_state       = r_state;
        n_item        = r_item;
        n_out         = r_out;
        n_out_valid   = r_out_valid;
        n_clr_addr    = r_clr_addr;
        n_set         = r_set;
        n_hit         = r_hit;
        n_way         = r_way;
        n_best        = r_best;
        n_scan        = r_scan;
        o_in_ready    = 1'b0;
        split_ld_quot = 1'b0;
        mem_rd_en     = 1'b0;
        mem_rd_addr   = r_set;
        mem_wr_en     = 1'b0;
        mem_wr_addr   = r_set;
        wr_valid      = rd_valid;
        wr_tag        = rd_tag;
        wr_frame      = rd_frame;
        wr_stamp      = rd_stamp;

        // Drop the result once taken
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            satlb_pkg::ST_CLEAR: begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = r_clr_addr;
                wr_valid    = '0;
                wr_tag      = '0;
                wr_frame    = '0;
                wr_stamp    = '0;
                if (r_clr_addr == SET_W'(SETS - 1)) begin
                    n_state = satlb_pkg::ST_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            satlb_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_item  = i_in_item;
                    n_state = satlb_pkg::ST_SPLIT;
                end
            end
            satlb_pkg::ST_SPLIT: begin
                split_ld_quot = 1'b1;
                n_state       = satlb_pkg::ST_READ;
            end
            satlb_pkg::ST_READ: begin
                mem_rd_en   = 1'b1;
                mem_rd_addr = split_rem;
                n_set       = split_rem;
                n_state     = satlb_pkg::ST_EVAL;
            end
            satlb_pkg::ST_EVAL: begin
                n_hit   = 1'b0;
                n_state = satlb_pkg::ST_COMMIT;
                case (r_item.op)
                    satlb_pkg::OP_LOOKUP: begin
                        n_hit = match_hit;
                        n_way = match_way;
                    end
                    satlb_pkg::OP_INSERT: begin
                        if (free_hit) begin
                            n_way = free_way;
                        end else if (WAYS == 1) begin
                            n_way = '0;
                        end else begin
                            n_best  = '0;
                            n_scan  = WAY_W'(1);
                            n_state = satlb_pkg::ST_SCAN;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            satlb_pkg::ST_SCAN: begin
                if (r_scan == WAY_W'(WAYS - 1)) begin
                    n_way   = best_next;
                    n_state = satlb_pkg::ST_COMMIT;
                end else begin
                    n_best = best_next;
                    n_scan = r_scan + 1'b1;
                end
            end
            satlb_pkg::ST_COMMIT: begin
                // Hold until the output register is free
                if (out_free) begin
                    n_out_valid     = 1'b1;
                    n_out.hit       = r_hit;
                    n_out.hit_frame = r_hit ? rd_frame[r_way] : '0;
                    n_state         = satlb_pkg::ST_IDLE;
                    case (r_item.op)
                        satlb_pkg::OP_LOOKUP: begin
                            if (r_hit) begin
                                mem_wr_en       = 1'b1;
                                wr_stamp[r_way] = r_item.time_stamp;
                            end
                        end
                        satlb_pkg::OP_INSERT: begin
                            mem_wr_en       = 1'b1;
                            wr_valid[r_way] = 1'b1;
                            wr_tag[r_way]   = item_tag;
                            wr_frame[r_way] = r_item.frame_number;
                            wr_stamp[r_way] = r_item.time_stamp;
                        end
                        satlb_pkg::OP_INVAL: begin
                            mem_wr_en = 1'b1;
                            wr_valid  = rd_valid & ~inv_mask;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            default: begin
                n_state = satlb_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= satlb_pkg::ST_CLEAR;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_item <= n_item;
        r_out  <= n_out;
        r_set  <= n_set;
        r_hit  <= n_hit;
        r_way  <= n_way;
        r_best <= n_best;
        r_scan <= n_scan;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

[design/satlb_check.sv]
// ---------------------------------------------------------------------------
// satlb_check
// Port-level checks for the translation buffer, attached to the top level
// by a bind statement.
// ---------------------------------------------------------------------------
module satlb_check (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input satlb_pkg::t_out_item o_out_item
);

    // Stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("result item changed while stalled");

    // Miss reports a zero frame
    a_miss_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_item.hit |-> o_out_item.hit_frame == '0)
        else $error("miss with nonzero frame");

    // One item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready |=> !o_in_ready)
        else $error("ready right after accept");

    // Clearing pass blocks input after reset
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("ready during reset clearing");

    // A new result never rises right after an accepted item
    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(i_in_valid && o_in_ready))
        else $error("result one cycle after accept");

endmodule

bind set_assoc_tlb_lru_unit satlb_check u_satlb_check (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
